### hw/rtl/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types, constants and helper functions of the Bayes-Ball relevance
// block: node mask type, sequencer states, action codes.
// ----------------------------------------------------------------------------
package bbr_pkg;

    // graph size and derived widths
    localparam int MAX_NODES = 16;
    localparam int NODE_IW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 4;
    localparam int MASK_W    = 16;

    // one bit per node
    typedef logic [MAX_NODES-1:0] t_nodes;
    typedef logic [NODE_IW-1:0]   t_node_idx;

    // action codes of an input beat
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    // nodes 0..n-1 are in use; a count above MAX_NODES saturates
    function automatic t_nodes used_nodes(input logic [CNT_W-1:0] n);
        t_nodes m;
        for (int i = 0; i < MAX_NODES; i++) begin
            m[i] = (32'(n) > 32'(i));
        end
        return m;
    endfunction

    // index of the lowest set bit, zero for an empty mask
    function automatic t_node_idx lowest_index(input t_nodes m);
        t_node_idx idx;
        idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = NODE_IW'(i);
            end
        end
        return idx;
    endfunction

endpackage

### hw/rtl/bayes_ball_relevance.sv
// ----------------------------------------------------------------------------
// bayes_ball_relevance
// Bayes-Ball relevance walk over a small DAG held as parent masks.
// ----------------------------------------------------------------------------
// A write beat (action 0) stores one node's parent mask and produces no
// result. A query beat (action 1) loads J and K at its accepting edge. It
// then serves one visit per cycle in a shared visit unit (lowest pending
// node first, visits from a child before visits from a parent), sees both
// pending masks empty, and hands the masks to the output register. The input
// side stalls from the query beat until that hand-over. The hand-over waits
// while an earlier result is still stalled in the output register. V, the
// number of visits served, is zero for an empty J, about two per node on a
// sparse graph, and is bounded by the J nodes plus the parents of each
// top-marked node plus the children of each bottom-marked node, at most
// MAX_NODES + 2 * MAX_NODES * MAX_NODES (528 for 16 nodes).
// Results wait in the output register, and write beats are taken while a
// result is still pending.
module bayes_ball_relevance
    import bbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: node_count
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_action,
    input  logic [IDX_W-1:0]  i_node_index,
    input  logic [MASK_W-1:0] i_parent_mask,
    input  logic [MASK_W-1:0] i_event_mask,
    input  logic [MASK_W-1:0] i_condition_mask,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_irrelevant_mask,
    output logic [MASK_W-1:0] o_requisite_prob_mask,
    output logic [MASK_W-1:0] o_requisite_obs_mask
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_node_count;
    t_nodes           r_rows [MAX_NODES];

    t_nodes r_used, r_kset;
    t_nodes r_visited, n_visited;
    t_nodes r_top, n_top;
    t_nodes r_bottom, n_bottom;
    t_nodes r_pend_child, n_pend_child;
    t_nodes r_pend_parent, n_pend_parent;

    logic              r_out_valid;
    logic [MASK_W-1:0] r_irr, r_prob, r_obs;

    logic      in_beat, query_beat, write_beat;
    logic      in_ready, step_en, load_result, out_free, pend_any;
    logic      from_child, in_k;
    t_nodes    src, sel_bit, parents, kids;
    t_node_idx sel;

    assign in_beat    = i_in_valid && !o_in_stall;
    assign query_beat = in_beat && (i_action == ACT_QUERY);
    assign write_beat = in_beat && (i_action == ACT_WRITE);
    assign pend_any   = (r_pend_child | r_pend_parent) != '0;
    assign out_free   = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (query_beat) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (!pend_any) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready    = 1'b0;
        step_en     = 1'b0;
        load_result = 1'b0;
        case (r_state)
            ST_IDLE:   in_ready    = 1'b1;
            ST_WALK:   step_en     = pend_any;
            ST_FINISH: load_result = out_free;
            default:   in_ready    = 1'b0;
        endcase
    end

    assign o_in_stall = !in_ready;

    // pick the next visit: lowest child-side node, else lowest parent-side node
    assign from_child = r_pend_child != '0;
    assign src        = from_child ? r_pend_child : r_pend_parent;
    assign sel        = lowest_index(src);
    assign sel_bit    = t_nodes'(1) << sel;
    assign in_k       = (r_kset & sel_bit) != '0;
    assign parents    = r_rows[sel] & r_used;

    // children of the selected node: column of the parent rows
    always_comb begin
        for (int c = 0; c < MAX_NODES; c++) begin
            kids[c] = r_used[c] & r_rows[c][sel];
        end
    end

    // shared visit unit: serve one visit, set marks, pass the ball on
    always_comb begin
        n_visited     = r_visited | sel_bit;
        n_top         = r_top;
        n_bottom      = r_bottom;
        n_pend_child  = r_pend_child;
        n_pend_parent = r_pend_parent;
        if (from_child) begin
            n_pend_child = r_pend_child & ~sel_bit;
            if (!in_k) begin
                if ((r_top & sel_bit) == '0) begin
                    n_top        = r_top | sel_bit;
                    n_pend_child = n_pend_child | parents;
                end
                if ((r_bottom & sel_bit) == '0) begin
                    n_bottom      = r_bottom | sel_bit;
                    n_pend_parent = r_pend_parent | kids;
                end
            end
        end else begin
            n_pend_parent = r_pend_parent & ~sel_bit;
            if (in_k) begin
                if ((r_top & sel_bit) == '0) begin
                    n_top        = r_top | sel_bit;
                    n_pend_child = r_pend_child | parents;
                end
            end else if ((r_bottom & sel_bit) == '0) begin
                n_bottom      = r_bottom | sel_bit;
                n_pend_parent = n_pend_parent | kids;
            end
        end
    end

    // control registers, graph store and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= CNT_W'(MAX_NODES);
            r_out_valid  <= 1'b0;
            for (int r = 0; r < MAX_NODES; r++) begin
                r_rows[r] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (write_beat && (32'(i_node_index) < MAX_NODES)) begin
                r_rows[i_node_index[NODE_IW-1:0]] <= i_parent_mask[MAX_NODES-1:0];
            end
            if (load_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk state: load on a query beat, advance one visit per cycle
    always_ff @(posedge i_clk) begin
        if (query_beat) begin
            r_used        <= used_nodes(r_node_count);
            r_kset        <= i_condition_mask[MAX_NODES-1:0] & used_nodes(r_node_count);
            r_pend_child  <= i_event_mask[MAX_NODES-1:0] & used_nodes(r_node_count);
            r_pend_parent <= '0;
            r_visited     <= '0;
            r_top         <= '0;
            r_bottom      <= '0;
        end else if (step_en) begin
            r_visited     <= n_visited;
            r_top         <= n_top;
            r_bottom      <= n_bottom;
            r_pend_child  <= n_pend_child;
            r_pend_parent <= n_pend_parent;
        end
    end

    // result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (load_result) begin
            r_irr  <= MASK_W'(r_used & ~r_bottom);
            r_prob <= MASK_W'(r_top & r_used);
            r_obs  <= MASK_W'(r_kset & r_visited);
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_irrelevant_mask     = r_irr;
    assign o_requisite_prob_mask = r_prob;
    assign o_requisite_obs_mask  = r_obs;

endmodule

### hw/rtl/bbr_checker.sv
// ----------------------------------------------------------------------------
// bbr_checker
// Port-level checks of the Bayes-Ball relevance block, bound to the top level.
// ----------------------------------------------------------------------------
module bbr_checker
    import bbr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic [CNT_W-1:0]  i_cfg_data,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              i_action,
    input logic [IDX_W-1:0]  i_node_index,
    input logic [MASK_W-1:0] i_parent_mask,
    input logic [MASK_W-1:0] i_event_mask,
    input logic [MASK_W-1:0] i_condition_mask,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [MASK_W-1:0] o_irrelevant_mask,
    input logic [MASK_W-1:0] o_requisite_prob_mask,
    input logic [MASK_W-1:0] o_requisite_obs_mask
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_irrelevant_mask)
            && $stable(o_requisite_prob_mask) && $stable(o_requisite_obs_mask)))
        else $error("stalled result beat changed");

    // observed nodes are never bottom-marked, so they are always irrelevant
    a_obs_irr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_requisite_obs_mask & ~o_irrelevant_mask) == '0))
        else $error("requisite observation node not in irrelevant set");

    // a top-marked node without a bottom mark must be a visited observed node
    a_prob_irr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_requisite_prob_mask & o_irrelevant_mask
            & ~o_requisite_obs_mask) == '0))
        else $error("top-marked unobserved node left without bottom mark");

    // a query beat starts a walk, so the input side stalls next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACT_QUERY)) |=> o_in_stall)
        else $error("input taken during a walk");

    // a write beat leaves the block ready
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACT_WRITE)) |=> !o_in_stall)
        else $error("write beat blocked the input");

endmodule

bind bayes_ball_relevance bbr_checker u_bbr_checker (.*);
